/* design/bmhpq_pkg.sv */
package bmhpq_pkg;

  // one stored request entry, 64 bits
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] pri;
    logic [31:0] start;
  } entry_t;

  localparam int unsigned EntryW = 64;

  // result status codes
  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // true when a ranks strictly above b: higher priority, then earlier start
  function automatic logic ranks_above(entry_t a, entry_t b);
    logic r;
    if (a.pri != b.pri) begin
      r = (a.pri > b.pri);
    end else begin
      r = (a.start < b.start);
    end
    return r;
  endfunction

endpackage

/* design/bmhpq_ram.sv */
module bmhpq_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

/* design/binary_max_heap_priority_queue.sv */
// channel | role   | handshake                | fields
// in      | input  | in_valid_i, in_ready_o   | operation_i, request_id_i, priority_req_i,
//         |        |                          | start_time_i
// out     | output | out_valid_o, out_ready_i | status_o, out_id_o, out_priority_o,
//         |        |                          | out_start_o, entry_count_o
//
// one operation at a time; each heap level walked is a read, then a compare and write
// back, through the single shared store; an insert climbs until it reaches the root
// or stops below a parent it does not outrank, a remove descends until it reaches a
// leaf or no child outranks it; insert on full and remove on empty go straight to the
// result
// the input is ready again as soon as the result is registered
// reset empties the heap at once (fill count only, the store needs no clearing)
// a finished result waits in the output register while the next transaction is taken;
// a result still held there stalls the sequencer in its last state
module binary_max_heap_priority_queue #(
  parameter int unsigned HEAP_DEPTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  operation_i,
  input  logic [15:0]           request_id_i,
  input  logic [15:0]           priority_req_i,
  input  logic [31:0]           start_time_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic [15:0]           out_id_o,
  output logic [15:0]           out_priority_o,
  output logic [31:0]           out_start_o,
  output logic [6:0]            entry_count_o
);
  import bmhpq_pkg::*;

  localparam int unsigned AW = $clog2(HEAP_DEPTH);
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned XW = AW + 2;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP     = 3'd1;
  localparam logic [2:0] S_UP_CMP = 3'd2;
  localparam logic [2:0] S_DEL_RD = 3'd3;
  localparam logic [2:0] S_DEL_LD = 3'd4;
  localparam logic [2:0] S_DN     = 3'd5;
  localparam logic [2:0] S_DN_CMP = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [AW-1:0] pos_q, pos_d;
  entry_t        cur_q, cur_d;
  entry_t        top_q, top_d;
  status_e       res_q, res_d;

  logic          out_valid_q, out_valid_d;
  status_e       ostat_q, ostat_d;
  entry_t        otop_q, otop_d;
  logic [6:0]    ocnt_q, ocnt_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
  entry_t        ram_wdata, ram_rdata_a, ram_rdata_b;

  logic [AW-1:0] parent_idx;
  logic [XW-1:0] left_x, right_x, fill_x;
  logic          left_ok, right_ok;
  entry_t        best;
  logic [AW-1:0] best_idx;

  bmhpq_ram #(
    .Width (EntryW),
    .Depth (HEAP_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .rdata_a_o (ram_rdata_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_b_o (ram_rdata_b)
  );

  // index arithmetic around the current position
  assign parent_idx = (pos_q - AW'(1)) >> 1;
  assign left_x     = {1'b0, pos_q, 1'b1};
  assign right_x    = left_x + XW'(1);
  assign fill_x     = XW'(fill_q);
  assign left_ok    = (left_x < fill_x);
  assign right_ok   = (right_x < fill_x);

  // pick the higher-ranked child, left on a tie
  always_comb begin
    if (right_ok && ranks_above(ram_rdata_b, ram_rdata_a)) begin
      best     = ram_rdata_b;
      best_idx = AW'(right_x);
    end else begin
      best     = ram_rdata_a;
      best_idx = AW'(left_x);
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // sequencer
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    pos_d       = pos_q;
    cur_d       = cur_q;
    top_d       = top_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    ostat_d     = ostat_q;
    otop_d      = otop_q;
    ocnt_d      = ocnt_q;
    ram_we      = 1'b0;
    ram_waddr   = pos_q;
    ram_wdata   = cur_q;
    ram_raddr_a = '0;
    ram_raddr_b = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          top_d = '0;
          if (operation_i == OP_INSERT) begin
            if (fill_q >= CW'(HEAP_DEPTH)) begin
              res_d   = ST_FULL;
              state_d = S_DONE;
            end else begin
              cur_d   = '{id: request_id_i, pri: priority_req_i, start: start_time_i};
              pos_d   = AW'(fill_q);
              fill_d  = fill_q + CW'(1);
              res_d   = ST_INSERTED;
              state_d = S_UP;
            end
          end else begin
            if (fill_q == '0) begin
              res_d   = ST_EMPTY;
              state_d = S_DONE;
            end else begin
              res_d   = ST_REMOVED;
              state_d = S_DEL_RD;
            end
          end
        end
      end
      S_UP: begin
        if (pos_q == '0) begin
          ram_we  = 1'b1;
          state_d = S_DONE;
        end else begin
          ram_raddr_a = parent_idx;
          state_d     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (ranks_above(cur_q, ram_rdata_a)) begin
          // parent moves down into the hole
          ram_wdata = ram_rdata_a;
          pos_d     = parent_idx;
          state_d   = S_UP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DEL_RD: begin
        ram_raddr_a = '0;
        ram_raddr_b = AW'(fill_q - CW'(1));
        fill_d      = fill_q - CW'(1);
        state_d     = S_DEL_LD;
      end
      S_DEL_LD: begin
        top_d   = ram_rdata_a;
        cur_d   = ram_rdata_b;
        pos_d   = '0;
        state_d = S_DN;
      end
      S_DN: begin
        if (!left_ok) begin
          ram_we  = 1'b1;
          state_d = S_DONE;
        end else begin
          ram_raddr_a = AW'(left_x);
          ram_raddr_b = right_ok ? AW'(right_x) : AW'(left_x);
          state_d     = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        ram_we = 1'b1;
        if (ranks_above(best, cur_q)) begin
          // best child moves up into the hole
          ram_wdata = best;
          pos_d     = best_idx;
          state_d   = S_DN;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          ostat_d     = res_q;
          otop_d      = top_q;
          ocnt_d      = 7'(fill_q);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    cur_q   <= cur_d;
    top_q   <= top_d;
    res_q   <= res_d;
    ostat_q <= ostat_d;
    otop_q  <= otop_d;
    ocnt_q  <= ocnt_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = ostat_q;
  assign out_id_o       = otop_q.id;
  assign out_priority_o = otop_q.pri;
  assign out_start_o    = otop_q.start;
  assign entry_count_o  = ocnt_q;

endmodule
